[rtl/core/hrcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrcp_pkg
// shared constants, error codes and result type of the command line parser
// ----------------------------------------------------------------------------
package hrcp_pkg;

    localparam int MAX_LINE = 256;
    localparam int MAX_DATA = 4;

    localparam int LEN_W   = $clog2(MAX_LINE + 1);
    localparam int BC_W    = $clog2(MAX_DATA + 1);
    localparam int DATA_W  = 8 * MAX_DATA;
    localparam int IN_W    = 8;
    localparam int RES_W   = 1 + 3 + 8 + 8 + 8 + 8 + 32 + 3 + 4;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_CMD     = 4'd1;
    localparam logic [3:0] ERR_DEVTYPE = 4'd2;
    localparam logic [3:0] ERR_DEVNUM  = 4'd3;
    localparam logic [3:0] ERR_PAGE    = 4'd4;
    localparam logic [3:0] ERR_ADDR    = 4'd5;
    localparam logic [3:0] ERR_LENGTH  = 4'd6;
    localparam logic [3:0] ERR_EXTRA   = 4'd7;
    localparam logic [3:0] ERR_RANGE   = 4'd8;
    localparam logic [3:0] ERR_TOOMANY = 4'd9;
    localparam logic [3:0] ERR_DATA    = 4'd10;
    localparam logic [3:0] ERR_NODATA  = 4'd11;
    localparam logic [3:0] ERR_TOOLONG = 4'd12;

    localparam logic [2:0] DEV_DC = 3'd0;
    localparam logic [2:0] DEV_FF = 3'd1;
    localparam logic [2:0] DEV_CL = 3'd2;
    localparam logic [2:0] DEV_MC = 3'd3;
    localparam logic [2:0] DEV_FP = 3'd4;

    // first field in the highest bits, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  error_code;
        logic [2:0]  data_count;
        logic [31:0] write_data;
        logic [7:0]  read_length;
        logic [7:0]  register_address;
        logic [7:0]  page_number;
        logic [7:0]  device_number;
        logic [2:0]  device_type;
        logic        is_write;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/hrcp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrcp_parser
// per-character parse state and next-state logic; builds the result on newline
// ----------------------------------------------------------------------------
module hrcp_parser (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_byte,
    output logic                        o_emit,
    output hrcp_pkg::t_result           o_result
);
    import hrcp_pkg::*;

    typedef enum logic [3:0] {
        PH_CMD, PH_CMD_SEP, PH_DEV1, PH_DEV2, PH_DEV_SEP, PH_DEVNUM,
        PH_PAGE, PH_ADDR, PH_RLEN, PH_RTAIL, PH_DATA, PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_digits, n_digits;
    logic [7:0]          r_acc, n_acc;
    logic [LEN_W-1:0]    r_len;
    logic [3:0]          r_err, n_err;
    logic                r_first_cr;
    logic                r_wr, n_wr;
    logic [2:0]          r_type, n_type;
    logic [7:0]          r_devnum, n_devnum;
    logic [7:0]          r_page, n_page;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_rlen, n_rlen;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [BC_W-1:0]     r_bc, n_bc;

    logic                sp, is_end, is_lf, hex_ok, in_range, empty_line, line_over;
    logic [3:0]          hex_val;

    function automatic logic [3:0] field_err(input t_phase ph);
        unique case (ph)
            PH_DEVNUM: field_err = ERR_DEVNUM;
            PH_PAGE:   field_err = ERR_PAGE;
            PH_ADDR:   field_err = ERR_ADDR;
            PH_RLEN:   field_err = ERR_LENGTH;
            default:   field_err = ERR_DATA;
        endcase
    endfunction

    // error after an end mark between tokens; the phase always becomes done
    function automatic logic [3:0] gap_err(input t_phase ph, input logic wr,
                                           input logic [7:0] rlen,
                                           input logic [BC_W-1:0] bc,
                                           input logic [3:0] err);
        logic [3:0] e;
        e = err;
        if (ph == PH_DEVNUM || ph == PH_PAGE || ph == PH_ADDR) begin
            e = field_err(ph);
        end else if (err == ERR_OK) begin
            if (!wr && (rlen == 8'd0 || rlen > 8'(MAX_DATA))) begin
                e = ERR_RANGE;
            end else if (wr && bc == '0) begin
                e = ERR_NODATA;
            end
        end
        return e;
    endfunction

    always_comb begin
        sp     = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
        is_lf  = (i_byte == CH_LF);
        is_end = (i_byte == CH_NUL) || (i_byte == CH_CR) || is_lf;
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= "0" && i_byte <= "9") begin
            hex_val = 4'(i_byte - "0");
        end else if (i_byte >= "A" && i_byte <= "F") begin
            hex_val = 4'(i_byte - "A" + 8'd10);
        end else if (i_byte >= "a" && i_byte <= "f") begin
            hex_val = 4'(i_byte - "a" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_err    = r_err;
        n_wr     = r_wr;
        n_type   = r_type;
        n_devnum = r_devnum;
        n_page   = r_page;
        n_addr   = r_addr;
        n_rlen   = r_rlen;
        n_data   = r_data;
        n_bc     = r_bc;
        unique case (r_phase)
            PH_CMD: begin
                if (!sp) begin
                    if (i_byte == "r" || i_byte == "R") begin
                        n_wr = 1'b0;
                        n_phase = PH_CMD_SEP;
                    end else if (i_byte == "w" || i_byte == "W") begin
                        n_wr = 1'b1;
                        n_phase = PH_CMD_SEP;
                    end else begin
                        n_err = ERR_CMD;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_CMD_SEP: begin
                if (sp) begin
                    n_phase = PH_DEV1;
                end else begin
                    n_err = ERR_CMD;
                    n_phase = PH_DONE;
                end
            end
            PH_DEV1: begin
                if (!sp) begin
                    if (i_byte == "D" || i_byte == "F" || i_byte == "C" || i_byte == "M") begin
                        n_acc = i_byte;
                        n_phase = PH_DEV2;
                    end else begin
                        n_err = ERR_DEVTYPE;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_DEV2: begin
                n_acc = 8'd0;
                n_phase = PH_DEV_SEP;
                if (r_acc == "D" && i_byte == "C") begin
                    n_type = DEV_DC;
                end else if (r_acc == "F" && i_byte == "F") begin
                    n_type = DEV_FF;
                end else if (r_acc == "C" && i_byte == "L") begin
                    n_type = DEV_CL;
                end else if (r_acc == "M" && i_byte == "C") begin
                    n_type = DEV_MC;
                end else if (r_acc == "F" && i_byte == "P") begin
                    n_type = DEV_FP;
                end else begin
                    n_err = ERR_DEVTYPE;
                    n_phase = PH_DONE;
                end
            end
            PH_DEV_SEP: begin
                if (sp) begin
                    n_phase = PH_DEVNUM;
                    n_digits = 2'd0;
                end else begin
                    n_err = ERR_DEVTYPE;
                    n_phase = PH_DONE;
                end
            end
            PH_DEVNUM, PH_PAGE, PH_ADDR, PH_RLEN, PH_DATA: begin
                if (r_digits == 2'd0) begin
                    if (sp) begin
                        n_phase = r_phase;
                    end else if (is_end) begin
                        n_err = gap_err(r_phase, r_wr, r_rlen, r_bc, r_err);
                        n_phase = PH_DONE;
                    end else if (r_phase == PH_DATA && r_bc >= BC_W'(MAX_DATA)) begin
                        n_err = ERR_TOOMANY;
                        n_phase = PH_DONE;
                    end else if (!hex_ok) begin
                        n_err = field_err(r_phase);
                        n_phase = PH_DONE;
                    end else begin
                        n_acc = {4'd0, hex_val};
                        n_digits = 2'd1;
                    end
                end else if (hex_ok && r_digits == 2'd1) begin
                    n_acc = {r_acc[3:0], hex_val};
                    n_digits = 2'd2;
                end else if (sp || is_end) begin
                    // commit the finished byte
                    unique case (r_phase)
                        PH_DEVNUM: begin
                            n_devnum = r_acc;
                            n_phase = PH_PAGE;
                        end
                        PH_PAGE: begin
                            n_page = r_acc;
                            n_phase = PH_ADDR;
                        end
                        PH_ADDR: begin
                            n_addr = r_acc;
                            n_phase = r_wr ? PH_DATA : PH_RLEN;
                        end
                        PH_RLEN: begin
                            n_rlen = r_acc;
                            n_phase = PH_RTAIL;
                        end
                        default: begin
                            if (r_bc < BC_W'(MAX_DATA)) begin
                                for (int i = 0; i < MAX_DATA; i++) begin
                                    if (r_bc == BC_W'(i)) begin
                                        n_data[i*8 +: 8] = r_acc;
                                    end
                                end
                                n_bc = r_bc + 1'b1;
                            end
                        end
                    endcase
                    n_digits = 2'd0;
                    n_acc = 8'd0;
                    if (is_end) begin
                        n_err = gap_err(n_phase, r_wr, n_rlen, n_bc, r_err);
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_err = field_err(r_phase);
                    n_phase = PH_DONE;
                end
            end
            PH_RTAIL: begin
                if (!sp) begin
                    n_err = is_end ? gap_err(r_phase, r_wr, r_rlen, r_bc, r_err) : ERR_EXTRA;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign in_range   = (r_len < LEN_W'(MAX_LINE - 1));
    assign line_over  = (r_len >= LEN_W'(MAX_LINE));
    assign empty_line = (r_len == '0) || (r_len == LEN_W'(1) && r_first_cr);
    assign o_emit     = is_lf && !empty_line;

    always_comb begin
        o_result = '0;
        if (line_over) begin
            o_result.error_code = ERR_TOOLONG;
        end else begin
            o_result.is_write         = n_wr;
            o_result.device_type      = n_type;
            o_result.device_number    = n_devnum;
            o_result.page_number      = n_page;
            o_result.register_address = n_addr;
            o_result.read_length      = n_rlen;
            o_result.write_data       = 32'(n_data);
            o_result.data_count       = 3'(n_bc);
            o_result.error_code       = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && is_lf)) begin
            r_phase    <= PH_CMD;
            r_digits   <= 2'd0;
            r_acc      <= 8'd0;
            r_len      <= '0;
            r_err      <= ERR_OK;
            r_first_cr <= 1'b0;
            r_wr       <= 1'b0;
            r_type     <= DEV_DC;
            r_devnum   <= 8'd0;
            r_page     <= 8'd0;
            r_addr     <= 8'd0;
            r_rlen     <= 8'd1;
            r_data     <= '0;
            r_bc       <= '0;
        end else if (i_step) begin
            if (in_range) begin
                if (r_len == '0) begin
                    r_first_cr <= (i_byte == CH_CR);
                end
                r_len    <= r_len + 1'b1;
                r_phase  <= n_phase;
                r_digits <= n_digits;
                r_acc    <= n_acc;
                r_err    <= n_err;
                r_wr     <= n_wr;
                r_type   <= n_type;
                r_devnum <= n_devnum;
                r_page   <= n_page;
                r_addr   <= n_addr;
                r_rlen   <= n_rlen;
                r_data   <= n_data;
                r_bc     <= n_bc;
            end else begin
                r_len <= LEN_W'(MAX_LINE);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/hrcp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrcp_out_reg
// result register driving the master-side stream
// ----------------------------------------------------------------------------
module hrcp_out_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire hrcp_pkg::t_result             i_result,
    output logic                               o_can_load,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [hrcp_pkg::TDATA_W-1:0]       o_m_tdata
);
    import hrcp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = TDATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

[rtl/core/hex_register_command_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_register_command_parser_unit
// streaming parser for text register read/write command lines
// ----------------------------------------------------------------------------
// One character is taken per beat and parsed on the fly, with no line buffer.
// A beat can be accepted in every cycle, the newline included, and the input
// stalls only when a newline result finds the result register full and not
// being drained. A result is offered on the master side once its newline
// beat has passed the input register and then the result register. Empty
// lines and lines holding only a carriage return give no result; a line of
// MAX_LINE or more characters reports too-long.
module hex_register_command_parser_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [hrcp_pkg::IN_W-1:0]     i_s_tdata,   // rx_byte
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // is_write, device_type, device_number, page_number, register_address,
    // read_length, write_data, data_count, error_code, zero pad
    output logic [hrcp_pkg::TDATA_W-1:0]       o_m_tdata
);
    import hrcp_pkg::*;

    logic            r_in_valid;
    logic [IN_W-1:0] r_in_byte;
    logic            emit, can_load, step;
    t_result         result;

    assign step       = r_in_valid && (!emit || can_load);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    hrcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    hrcp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && emit),
        .i_result   (result),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

[dv/hrcp_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcp_result_checker
// Watches both streams of the command line parser. Every accepted input
// beat is run through a character-level model of the line grammar. A newline
// that closes a line (not empty, not a lone CR) queues the expected fields.
// Every result beat is compared field by field with the oldest queued line.
// ----------------------------------------------------------------------------
module hrcp_result_checker
    import hrcp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [IN_W-1:0]    i_s_tdata,    // rx_byte
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    // is_write, device_type, device_number, page_number, register_address,
    // read_length, write_data, data_count, error_code, zero pad
    input  wire logic [TDATA_W-1:0] i_m_tdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef enum logic [3:0] {
        ST_LETTER,
        ST_LETTER_GAP,
        ST_TYPE_HI,
        ST_TYPE_LO,
        ST_TYPE_GAP,
        ST_DEVNUM,
        ST_PAGE,
        ST_ADDR,
        ST_LEN,
        ST_LEN_TAIL,
        ST_WDATA,
        ST_SKIP
    } t_parse_state;

    t_parse_state st;
    int           ndig;
    logic [7:0]   acc;
    int           line_len;
    logic [3:0]   err;
    logic         lead_cr;
    logic         is_wr;
    logic [2:0]   dtype;
    logic [7:0]   devnum;
    logic [7:0]   page;
    logic [7:0]   addr;
    logic [7:0]   rlen;
    logic [31:0]  wdata;
    int           nbytes;
    int           fails = 0;
    t_result      expected_q[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fails < 40)
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    function automatic void clear_line_state();
        st      = ST_LETTER;
        ndig    = 0;
        acc     = 8'h00;
        line_len = 0;
        err     = ERR_OK;
        lead_cr = 1'b0;
        is_wr   = 1'b0;
        dtype   = DEV_DC;
        devnum  = 8'h00;
        page    = 8'h00;
        addr    = 8'h00;
        rlen    = 8'd1;
        wdata   = 32'h0;
        nbytes  = 0;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
        return -1;
    endfunction

    function automatic void abort_line(input logic [3:0] code);
        err = code;
        st  = ST_SKIP;
    endfunction

    function automatic void close_line();
        if (err == ERR_OK) begin
            if (!is_wr && (rlen < 8'd1 || rlen > MAX_DATA))
                err = ERR_RANGE;
            else if (is_wr && nbytes == 0)
                err = ERR_NODATA;
        end
        st = ST_SKIP;
    endfunction

    function automatic logic [3:0] token_error();
        case (st)
            ST_DEVNUM: return ERR_DEVNUM;
            ST_PAGE:   return ERR_PAGE;
            ST_ADDR:   return ERR_ADDR;
            ST_LEN:    return ERR_LENGTH;
            default:   return ERR_DATA;
        endcase
    endfunction

    function automatic void store_byte();
        case (st)
            ST_DEVNUM: begin
                devnum = acc;
                st = ST_PAGE;
            end
            ST_PAGE: begin
                page = acc;
                st = ST_ADDR;
            end
            ST_ADDR: begin
                addr = acc;
                st = is_wr ? ST_WDATA : ST_LEN;
            end
            ST_LEN: begin
                rlen = acc;
                st = ST_LEN_TAIL;
            end
            default: begin
                if (nbytes < MAX_DATA) begin
                    wdata[8*nbytes +: 8] = acc;
                    nbytes++;
                end
            end
        endcase
        ndig = 0;
        acc  = 8'h00;
    endfunction

    // end mark seen while waiting for the next token
    function automatic void gap_end();
        if (st == ST_DEVNUM || st == ST_PAGE || st == ST_ADDR)
            abort_line(token_error());
        else
            close_line();
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic       blank;
        logic       term;
        logic [7:0] prev;
        int         h;
        blank = (c == CH_SPACE || c == CH_TAB);
        term  = (c == CH_NUL || c == CH_CR || c == CH_LF);
        h     = nibble_of(c);
        case (st)
            ST_LETTER: begin
                if (!blank) begin
                    if (c == "r" || c == "R") begin
                        is_wr = 1'b0;
                        st = ST_LETTER_GAP;
                    end else if (c == "w" || c == "W") begin
                        is_wr = 1'b1;
                        st = ST_LETTER_GAP;
                    end else begin
                        abort_line(ERR_CMD);
                    end
                end
            end
            ST_LETTER_GAP: begin
                if (blank) st = ST_TYPE_HI;
                else abort_line(ERR_CMD);
            end
            ST_TYPE_HI: begin
                if (!blank) begin
                    if (c == "D" || c == "F" || c == "C" || c == "M") begin
                        acc = c;
                        st = ST_TYPE_LO;
                    end else begin
                        abort_line(ERR_DEVTYPE);
                    end
                end
            end
            ST_TYPE_LO: begin
                prev = acc;
                acc  = 8'h00;
                st   = ST_TYPE_GAP;
                if (prev == "D" && c == "C") dtype = DEV_DC;
                else if (prev == "F" && c == "F") dtype = DEV_FF;
                else if (prev == "C" && c == "L") dtype = DEV_CL;
                else if (prev == "M" && c == "C") dtype = DEV_MC;
                else if (prev == "F" && c == "P") dtype = DEV_FP;
                else abort_line(ERR_DEVTYPE);
            end
            ST_TYPE_GAP: begin
                if (blank) begin
                    st = ST_DEVNUM;
                    ndig = 0;
                end else begin
                    abort_line(ERR_DEVTYPE);
                end
            end
            ST_DEVNUM, ST_PAGE, ST_ADDR, ST_LEN, ST_WDATA: begin
                if (ndig == 0) begin
                    if (!blank) begin
                        if (term) gap_end();
                        else if (st == ST_WDATA && nbytes >= MAX_DATA) abort_line(ERR_TOOMANY);
                        else if (h < 0) abort_line(token_error());
                        else begin
                            acc = 8'(h);
                            ndig = 1;
                        end
                    end
                end else if (h >= 0 && ndig == 1) begin
                    acc = {acc[3:0], 4'(h)};
                    ndig = 2;
                end else if (blank || term) begin
                    store_byte();
                    if (term) gap_end();
                end else begin
                    abort_line(token_error());
                end
            end
            ST_LEN_TAIL: begin
                if (!blank) begin
                    if (term) close_line();
                    else abort_line(ERR_EXTRA);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        t_result r;
        r = '0;
        if (c != CH_LF) begin
            if (line_len < MAX_LINE - 1) begin
                if (line_len == 0) lead_cr = (c == CH_CR);
                line_len++;
                parse_char(c);
            end else begin
                line_len = MAX_LINE;
            end
        end else if (line_len >= MAX_LINE) begin
            r.error_code = ERR_TOOLONG;
            expected_q.push_back(r);
            clear_line_state();
        end else if (line_len == 0 || (line_len == 1 && lead_cr)) begin
            clear_line_state();
        end else begin
            if (st != ST_SKIP) parse_char(c);
            r.is_write         = is_wr;
            r.device_type      = dtype;
            r.device_number    = devnum;
            r.page_number      = page;
            r.register_address = addr;
            r.read_length      = rlen;
            r.write_data       = wdata;
            r.data_count       = 3'(nbytes);
            r.error_code       = err;
            expected_q.push_back(r);
            clear_line_state();
        end
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("result beat with no line pending", got.error_code, 0);
        end else begin
            want = expected_q.pop_front();
            if (got.is_write !== want.is_write)
                report_mismatch("is_write", got.is_write, want.is_write);
            if (got.device_type !== want.device_type)
                report_mismatch("device_type", got.device_type, want.device_type);
            if (got.device_number !== want.device_number)
                report_mismatch("device_number", got.device_number, want.device_number);
            if (got.page_number !== want.page_number)
                report_mismatch("page_number", got.page_number, want.page_number);
            if (got.register_address !== want.register_address)
                report_mismatch("register_address", got.register_address,
                                want.register_address);
            if (got.read_length !== want.read_length)
                report_mismatch("read_length", got.read_length, want.read_length);
            if (got.write_data !== want.write_data)
                report_mismatch("write_data", got.write_data, want.write_data);
            if (got.data_count !== want.data_count)
                report_mismatch("data_count", got.data_count, want.data_count);
            if (got.error_code !== want.error_code)
                report_mismatch("error_code", got.error_code, want.error_code);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line_state();
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) take_byte(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_result(t_result'(i_m_tdata[RES_W-1:0]));
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

[dv/hex_register_command_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_register_command_parser_unit_tb
// Feeds text command lines into the parser one character per beat: a
// directed set covering every command, device type, error and line-length
// corner, then random lines (mostly well formed, some corrupted, some noise)
// under several sender and receiver idling mixes and one long receiver
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hex_register_command_parser_unit_tb;
    import hrcp_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;       // rx_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // is_write, device_type, device_number, page_number, register_address,
    // read_length, write_data, data_count, error_code, zero pad
    logic [TDATA_W-1:0] m_tdata;
    int                 fail_count;
    int                 pending;

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_req = 0;
    int                 hold_left = 0;
    int                 items_sent = 0;
    logic [7:0]         line_buf[$];
    string              dev_tag[5] = '{"DC", "FF", "CL", "MC", "FP"};

    hex_register_command_parser_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hrcp_result_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req != 0) begin
            hold_left = 300;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_beat(s[k]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? "a" : "A";
        return (v < 4'd10) ? 8'h30 + 8'(v) : base + 8'(v) - 8'd10;
    endfunction

    task automatic put_blanks(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
    endtask

    task automatic put_hex_token(input logic [7:0] v);
        if (v < 8'd16 && $urandom_range(0, 1) != 0) begin
            line_buf.push_back(hex_char(v[3:0]));
        end else begin
            line_buf.push_back(hex_char(v[7:4]));
            line_buf.push_back(hex_char(v[3:0]));
        end
        // occasional third digit
        if ($urandom_range(0, 39) == 0) line_buf.push_back(hex_char(4'($urandom)));
    endtask

    task automatic build_line();
        int kind;
        int pick;
        int nd;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            if (kind < 2) line_buf.push_back(CH_CR);
        end else if (kind < 12) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            put_blanks(0, 2);
            pick = $urandom_range(0, 3);
            line_buf.push_back(pick == 0 ? "r" : pick == 1 ? "R" : pick == 2 ? "w" : "W");
            put_blanks(1, 2);
            pick = $urandom_range(0, 4);
            line_buf.push_back(dev_tag[pick][0]);
            line_buf.push_back(dev_tag[pick][1]);
            repeat (3) begin
                put_blanks(1, 2);
                put_hex_token(8'($urandom_range(0, 255)));
            end
            if (line_buf[line_buf.size() - 1] != 8'h00 && (line_buf[0] == "w" ||
                    line_buf[0] == "W" || line_buf[$urandom_range(0, 0)] == "w")) begin
            end
            if (pick >= 0) begin
                nd = 0;
                for (int k = 0; k < line_buf.size(); k++) begin
                    if (line_buf[k] == "w" || line_buf[k] == "W") nd = 1;
                    if (line_buf[k] == "r" || line_buf[k] == "R") break;
                    if (nd != 0) break;
                end
                if (nd != 0) begin
                    pick = $urandom_range(0, 9);
                    nd = (pick < 1) ? 0 : (pick > 8) ? 5 : (pick + 1) / 2;
                    repeat (nd) begin
                        put_blanks(1, 2);
                        put_hex_token(8'($urandom_range(0, 255)));
                    end
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick >= 3) begin
                        put_blanks(1, 2);
                        if (pick == 8)
                            put_hex_token(($urandom_range(0, 1) != 0) ? 8'd0
                                          : 8'($urandom_range(5, 255)));
                        else
                            put_hex_token(8'($urandom_range(1, 4)));
                        if (pick == 9) begin
                            put_blanks(1, 2);
                            put_hex_token(8'($urandom_range(0, 255)));
                        end
                    end
                end
            end
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                line_buf.push_back(pick == 0 ? CH_CR : CH_NUL);
                repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                put_blanks(0, 1);
            end
            if ($urandom_range(0, 3) == 0)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        line_buf.push_back(CH_LF);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            build_line();
            foreach (line_buf[k]) send_beat(line_buf[k]);
            line_buf.delete();
        end
        drain();
    endtask

    initial begin
        int pad;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        send_text("r DC 0 0 0\n");
        send_text("W FF ff FF Ff 00 ff 7 a5\n");
        send_text("R CL 1 2 3 4\n");
        send_text("\t w MC A b C 1 2 3 4 5\n");
        send_text("r FP 12 34 56 0\n");
        send_text("r DC 1 2 3 4 5\n");
        send_text("w DC 1 2 3\n");
        send_text("x\n");
        send_text("rDC\n");
        send_text("r DX 1 2 3\n");
        send_text("r DCX 1 2 3\n");
        send_text("r DC 123 4 5\n");
        send_text("r DC 1 g 5\n");
        send_text("r DC 1 2\n");
        send_text("r DC 1 2 3 z\n");
        send_text("w DC 1 2 3 4 q\n");
        send_text("\n");
        send_text("\r\n");
        send_text("\r\r\n");
        send_text("r DC 1 2 3\r junk\n");
        send_text("w FP 1 2 3 44");
        send_beat(CH_NUL);
        send_text("zz\n");
        // longest accepted line, then the shortest too-long one
        for (pad = 245; pad <= 246; pad++) begin
            send_text("r DC 1 2 3");
            repeat (pad) send_beat(CH_SPACE);
            send_beat(CH_LF);
        end
        drain();

        run_phase(0, 0, 60);
        run_phase(74, 0, 60);
        run_phase(0, 74, 60);
        run_phase(14, 14, 60);

        hold_req = 1;
        run_phase(0, 0, 40);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
